FILE: sv/contour_cell_segments_assert.svh
// Assertion macros for the contour cell segment block.
// Needs clk and rst in the scope of the module that uses them.
`ifndef CONTOUR_CELL_SEGMENTS_ASSERT_SVH
`define CONTOUR_CELL_SEGMENTS_ASSERT_SVH

// same-cycle implication
`define CCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ccs_pkg.sv
// Shared constants, types and lookup functions for the contour cell segment block.
// No dependencies.
`default_nettype none

package ccs_pkg;

  localparam int GRID_DIM   = 1024;
  localparam int SAMPLE_W   = 24;
  localparam int CELL_W     = 10;
  localparam int COORD_W    = 18;
  localparam int FRAC       = 8;
  localparam int H_W        = SAMPLE_W + 3;   // difference scaled by 4
  localparam int DEN_W      = H_W + 1;
  localparam int Q_W        = 10;             // floor(512 * n / d), n <= d
  localparam int DIV_STAGES = Q_W;
  localparam int NTRI       = 4;
  localparam int LANES      = 2 * NTRI;

  localparam logic [CELL_W-1:0] CELL_MAX = CELL_W'(GRID_DIM - 2);

  // corner offsets, bit k for corner k
  localparam logic [NTRI-1:0] OFF_X = 4'b0110;
  localparam logic [NTRI-1:0] OFF_Y = 4'b1100;

  // triangle vertex codes: corner m, centre, next corner
  localparam logic [1:0] VX_A = 2'd0;
  localparam logic [1:0] VX_B = 2'd1;
  localparam logic [1:0] VX_C = 2'd2;

  // sign classes
  localparam logic [1:0] SG_NEG  = 2'd0;
  localparam logic [1:0] SG_ZERO = 2'd1;
  localparam logic [1:0] SG_POS  = 2'd2;

  // segment cases
  localparam logic [3:0] CS_NONE  = 4'd0;
  localparam logic [3:0] CS_AB    = 4'd1;
  localparam logic [3:0] CS_BC    = 4'd2;
  localparam logic [3:0] CS_CA    = 4'd3;
  localparam logic [3:0] CS_A_EBC = 4'd4;
  localparam logic [3:0] CS_B_ECA = 4'd5;
  localparam logic [3:0] CS_C_EAB = 4'd6;
  localparam logic [3:0] CS_EAB_EBC = 4'd7;
  localparam logic [3:0] CS_EBC_ECA = 4'd8;
  localparam logic [3:0] CS_ECA_EAB = 4'd9;

  localparam logic [3:0] CASE_TAB [27] = '{
    CS_NONE,    CS_NONE,    CS_EBC_ECA,
    CS_NONE,    CS_BC,      CS_B_ECA,
    CS_EAB_EBC, CS_C_EAB,   CS_ECA_EAB,
    CS_NONE,    CS_CA,      CS_A_EBC,
    CS_AB,      CS_CA,      CS_AB,
    CS_A_EBC,   CS_CA,      CS_NONE,
    CS_ECA_EAB, CS_C_EAB,   CS_EAB_EBC,
    CS_B_ECA,   CS_BC,      CS_NONE,
    CS_EBC_ECA, CS_NONE,    CS_NONE
  };

  typedef struct packed {
    logic       is_edge;
    logic [1:0] p;
    logic [1:0] q;
  } ep_t;

  typedef struct packed {
    logic [H_W-1:0]   n;
    logic [DEN_W-1:0] d;
  } lane_in_t;

  typedef struct packed {
    logic                  active;
    logic [CELL_W-1:0]     cx;
    logic [CELL_W-1:0]     cy;
    logic [NTRI-1:0][3:0]  cs;
  } side_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } seg_t;

  function automatic logic [1:0] sgn_code(logic signed [H_W-1:0] h);
    if (h[H_W-1]) return SG_NEG;
    else if (h == '0) return SG_ZERO;
    else return SG_POS;
  endfunction

  function automatic logic [3:0] case_of(logic [1:0] sa, logic [1:0] sb, logic [1:0] sc);
    logic [4:0] idx;
    idx = sa * 5'd9 + sb * 5'd3 + {3'b0, sc};
    if (idx > 5'd26) return CS_NONE;
    return CASE_TAB[idx];
  endfunction

  function automatic ep_t ep_of(logic [3:0] cs, logic is_end);
    ep_t s;
    ep_t e;
    s = '{is_edge: 1'b0, p: VX_A, q: VX_A};
    e = s;
    unique case (cs)
      CS_AB:      begin s = '{1'b0, VX_A, VX_A}; e = '{1'b0, VX_B, VX_B}; end
      CS_BC:      begin s = '{1'b0, VX_B, VX_B}; e = '{1'b0, VX_C, VX_C}; end
      CS_CA:      begin s = '{1'b0, VX_C, VX_C}; e = '{1'b0, VX_A, VX_A}; end
      CS_A_EBC:   begin s = '{1'b0, VX_A, VX_A}; e = '{1'b1, VX_B, VX_C}; end
      CS_B_ECA:   begin s = '{1'b0, VX_B, VX_B}; e = '{1'b1, VX_C, VX_A}; end
      CS_C_EAB:   begin s = '{1'b0, VX_C, VX_C}; e = '{1'b1, VX_A, VX_B}; end
      CS_EAB_EBC: begin s = '{1'b1, VX_A, VX_B}; e = '{1'b1, VX_B, VX_C}; end
      CS_EBC_ECA: begin s = '{1'b1, VX_B, VX_C}; e = '{1'b1, VX_C, VX_A}; end
      CS_ECA_EAB: begin s = '{1'b1, VX_C, VX_A}; e = '{1'b1, VX_A, VX_B}; end
      default:    begin s = '{1'b0, VX_A, VX_A}; e = s; end
    endcase
    return is_end ? e : s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ccs_front.sv
// Front stages: level differences, centre value, case lookup and divider operands.
// Depends on ccs_pkg.
`default_nettype none

module ccs_front import ccs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [SAMPLE_W-1:0] corner_00,
  input  logic signed [SAMPLE_W-1:0] corner_10,
  input  logic signed [SAMPLE_W-1:0] corner_11,
  input  logic signed [SAMPLE_W-1:0] corner_01,
  input  logic [CELL_W-1:0]          cell_x,
  input  logic [CELL_W-1:0]          cell_y,
  input  logic signed [SAMPLE_W-1:0] contour_level,
  output logic                       cell_valid,
  output side_t                      side,
  output lane_in_t [LANES-1:0]       lanes
);

  // stage 1
  logic                       v1;
  logic signed [SAMPLE_W:0]   d1 [NTRI];
  logic [CELL_W-1:0]          cx1, cy1;
  // stage 2
  logic                       v2;
  logic signed [H_W-1:0]      hc2 [NTRI];
  logic signed [H_W-1:0]      h02;
  logic                       act2;
  logic [CELL_W-1:0]          cx2, cy2;
  // stage 3 operands
  logic [NTRI-1:0][3:0]       cs_c;
  ep_t                        ep_c [LANES];
  logic signed [H_W-1:0]      hp_c [LANES];
  logic signed [H_W-1:0]      hq_c [LANES];
  logic signed [DEN_W-1:0]    den_c [LANES];
  lane_in_t [LANES-1:0]       lanes_c;
  logic                       all_pos, all_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      cell_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      cell_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= (SAMPLE_W+1)'(corner_00) - (SAMPLE_W+1)'(contour_level);
      d1[1] <= (SAMPLE_W+1)'(corner_10) - (SAMPLE_W+1)'(contour_level);
      d1[2] <= (SAMPLE_W+1)'(corner_11) - (SAMPLE_W+1)'(contour_level);
      d1[3] <= (SAMPLE_W+1)'(corner_01) - (SAMPLE_W+1)'(contour_level);
      cx1 <= (cell_x > CELL_MAX) ? CELL_MAX : cell_x;
      cy1 <= (cell_y > CELL_MAX) ? CELL_MAX : cell_y;
    end
  end

  // level outside the corner range: every difference has the same strict sign
  always_comb begin
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int k = 0; k < NTRI; k++) begin
      all_pos &= (d1[k] > 0);
      all_neg &= d1[k][SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NTRI; k++) hc2[k] <= H_W'(d1[k]) <<< 2;
      h02  <= H_W'(d1[0]) + H_W'(d1[1]) + H_W'(d1[2]) + H_W'(d1[3]);
      act2 <= !(all_pos || all_neg);
      cx2  <= cx1;
      cy2  <= cy1;
    end
  end

  always_comb begin
    for (int t = 0; t < NTRI; t++) begin
      cs_c[t] = case_of(sgn_code(hc2[t]), sgn_code(h02), sgn_code(hc2[(t+1) % NTRI]));
      for (int e = 0; e < 2; e++) begin
        ep_c[2*t+e] = ep_of(cs_c[t], e[0]);
        hp_c[2*t+e] = (ep_c[2*t+e].p == VX_A) ? hc2[t] :
                      (ep_c[2*t+e].p == VX_B) ? h02 : hc2[(t+1) % NTRI];
        hq_c[2*t+e] = (ep_c[2*t+e].q == VX_A) ? hc2[t] :
                      (ep_c[2*t+e].q == VX_B) ? h02 : hc2[(t+1) % NTRI];
        den_c[2*t+e] = DEN_W'(hp_c[2*t+e]) - DEN_W'(hq_c[2*t+e]);
        // vertex endpoints and a zero divisor give a zero quotient
        if (!ep_c[2*t+e].is_edge || den_c[2*t+e] == '0) begin
          lanes_c[2*t+e].n = '0;
          lanes_c[2*t+e].d = DEN_W'(1);
        end else begin
          lanes_c[2*t+e].n = hp_c[2*t+e][H_W-1] ? H_W'(-hp_c[2*t+e]) : H_W'(hp_c[2*t+e]);
          lanes_c[2*t+e].d = den_c[2*t+e][DEN_W-1] ? DEN_W'(-den_c[2*t+e])
                                                   : DEN_W'(den_c[2*t+e]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes       <= lanes_c;
      side.active <= act2;
      side.cx     <= cx2;
      side.cy     <= cy2;
      side.cs     <= cs_c;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ccs_div.sv
// Pipelined restoring divider, one quotient bit per stage: q = floor(512 * n / d), n <= d.
// Depends on ccs_pkg.
`default_nettype none

module ccs_div import ccs_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  lane_in_t       din,
  output logic [Q_W-1:0] q
);

  logic [DEN_W-1:0] rem  [DIV_STAGES];
  logic [DEN_W-1:0] dv   [DIV_STAGES];
  logic [Q_W-1:0]   qs   [DIV_STAGES];
  logic [DEN_W:0]   trial_c [DIV_STAGES];
  logic             bit_c   [DIV_STAGES];
  logic [DEN_W-1:0] rem_c   [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      // first stage tests n >= d for the top bit, the rest shift in
      if (k == 0) begin
        trial_c[k] = {2'b00, din.n};
        bit_c[k]   = trial_c[k] >= {1'b0, din.d};
        rem_c[k]   = bit_c[k] ? DEN_W'(trial_c[k] - {1'b0, din.d}) : DEN_W'(trial_c[k]);
      end else begin
        trial_c[k] = {rem[k-1], 1'b0};
        bit_c[k]   = trial_c[k] >= {1'b0, dv[k-1]};
        rem_c[k]   = bit_c[k] ? DEN_W'(trial_c[k] - {1'b0, dv[k-1]}) : DEN_W'(trial_c[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem[k] <= rem_c[k];
        if (k == 0) begin
          dv[k] <= din.d;
          qs[k] <= Q_W'(bit_c[k]);
        end else begin
          dv[k] <= dv[k-1];
          qs[k] <= {qs[k-1][Q_W-2:0], bit_c[k]};
        end
      end
    end
  end

  assign q = qs[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: sv/ccs_ser.sv
// Endpoints from quotients; segment buffer; output reg, one beat per unstalled cycle.
// Depends on ccs_pkg.
`default_nettype none

module ccs_ser import ccs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cell_valid,
  input  side_t                      side,
  input  logic [LANES-1:0][Q_W-1:0]  quot,
  input  logic                       out_stall,
  output logic                       take_ok,
  output logic                       out_valid,
  output logic [COORD_W-1:0]         start_x,
  output logic [COORD_W-1:0]         start_y,
  output logic [COORD_W-1:0]         end_x,
  output logic [COORD_W-1:0]         end_y,
  output logic                       last_segment
);

  ep_t                 ep_c [LANES];
  logic [COORD_W-1:0]  px_c [LANES];
  logic [COORD_W-1:0]  py_c [LANES];
  seg_t [NTRI-1:0]     new_seg;
  logic [NTRI-1:0]     new_mask;
  seg_t                buf_seg [NTRI];
  logic [NTRI-1:0]     buf_mask;
  logic [NTRI-1:0]     mask_left;
  logic [1:0]          pick;
  logic                has_any;
  logic                load_out;

  // position in half cells
  function automatic logic [CELL_W:0] half_pos(logic [1:0] v, logic [CELL_W-1:0] c,
                                               logic off_a, logic off_c);
    if (v == VX_B) return {c, 1'b1};
    else if (v == VX_A) return {c, 1'b0} + (CELL_W+1)'({off_a, 1'b0});
    else return {c, 1'b0} + (CELL_W+1)'({off_c, 1'b0});
  endfunction

  function automatic logic [COORD_W-1:0] coord(logic is_edge, logic [CELL_W:0] p2,
                                               logic [CELL_W:0] q2, logic [Q_W-1:0] qv);
    logic signed [CELL_W+1:0] delta;
    logic [Q_W:0]             r256, r128;
    logic [COORD_W:0]         base, r, res;
    base  = (COORD_W+1)'({p2, (FRAC-1)'(0)});
    delta = $signed({1'b0, q2}) - $signed({1'b0, p2});
    r256  = ({1'b0, qv} + (Q_W+1)'(1)) >> 1;
    r128  = ({2'b00, qv[Q_W-1:1]} + (Q_W+1)'(1)) >> 1;
    if (delta == 2 || delta == -2) r = (COORD_W+1)'(r256);
    else if (delta == 1 || delta == -1) r = (COORD_W+1)'(r128);
    else r = '0;
    res = delta[CELL_W+1] ? base - r : base + r;
    return is_edge ? COORD_W'(res) : COORD_W'(base);
  endfunction

  always_comb begin
    for (int t = 0; t < NTRI; t++) begin
      for (int e = 0; e < 2; e++) begin
        ep_c[2*t+e] = ep_of(side.cs[t], e[0]);
        px_c[2*t+e] = coord(ep_c[2*t+e].is_edge,
          half_pos(ep_c[2*t+e].p, side.cx, OFF_X[t], OFF_X[(t+1) % NTRI]),
          half_pos(ep_c[2*t+e].q, side.cx, OFF_X[t], OFF_X[(t+1) % NTRI]),
          quot[2*t+e]);
        py_c[2*t+e] = coord(ep_c[2*t+e].is_edge,
          half_pos(ep_c[2*t+e].p, side.cy, OFF_Y[t], OFF_Y[(t+1) % NTRI]),
          half_pos(ep_c[2*t+e].q, side.cy, OFF_Y[t], OFF_Y[(t+1) % NTRI]),
          quot[2*t+e]);
      end
      new_seg[t]  = '{sx: px_c[2*t], sy: py_c[2*t], ex: px_c[2*t+1], ey: py_c[2*t+1]};
      new_mask[t] = side.active && (side.cs[t] != CS_NONE);
    end
  end

  always_comb begin
    pick = '0;
    for (int k = NTRI-1; k >= 0; k--) begin
      if (buf_mask[k]) pick = 2'(k);
    end
  end

  assign has_any   = |buf_mask;
  assign mask_left = buf_mask & ~(NTRI'(1) << pick);
  assign load_out  = !out_valid || !out_stall;
  // a new cell may land once the buffer is drained by this cycle's beat
  assign take_ok   = load_out ? (mask_left == '0) : !has_any;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      buf_mask  <= '0;
    end else begin
      if (load_out) out_valid <= has_any;
      if (take_ok && cell_valid) buf_mask <= new_mask;
      else if (load_out) buf_mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && has_any) begin
      start_x      <= buf_seg[pick].sx;
      start_y      <= buf_seg[pick].sy;
      end_x        <= buf_seg[pick].ex;
      end_y        <= buf_seg[pick].ey;
      last_segment <= (mask_left == '0);
    end
    if (take_ok && cell_valid) begin
      for (int k = 0; k < NTRI; k++) buf_seg[k] <= new_seg[k];
    end
  end

endmodule

`default_nettype wire

FILE: sv/contour_cell_segments.sv
// Top level of the contour cell segment block: level register, front stages,
// eight divider lanes with their sideband line, and the segment serialiser.
// Depends on ccs_pkg, ccs_front, ccs_div, ccs_ser and contour_cell_segments_assert.svh.
//
//   channel | signals                                   | handshake
//   cfg     | level_we, level_wdata                     | write on level_we
//   in      | corner_00..corner_01, cell_x, cell_y      | in_valid / in_stall
//   out     | start_x, start_y, end_x, end_y, last_seg. | out_valid / out_stall
//
// The first beat of a cell passes 3 front stages, 10 divider stages (one quotient bit each),
// the 4-slot segment buffer, then the output reg.
// A cell holds the buffer until its last segment is loaded out, so one cell a cycle
// enters while cells give at most one segment and out_stall is low, and fewer otherwise.
// rst is synchronous: it clears valids, the buffer and sets the level to 0.
// The whole pipe halts only while its last stage holds a cell the buffer cannot take (out_stall or a cell draining).
`default_nettype none

module contour_cell_segments import ccs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       level_we,
  input  logic signed [SAMPLE_W-1:0] level_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] corner_00,
  input  logic signed [SAMPLE_W-1:0] corner_10,
  input  logic signed [SAMPLE_W-1:0] corner_11,
  input  logic signed [SAMPLE_W-1:0] corner_01,
  input  logic [CELL_W-1:0]          cell_x,
  input  logic [CELL_W-1:0]          cell_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [COORD_W-1:0]         start_x,
  output logic [COORD_W-1:0]         start_y,
  output logic [COORD_W-1:0]         end_x,
  output logic [COORD_W-1:0]         end_y,
  output logic                       last_segment
);

`include "contour_cell_segments_assert.svh"

  logic signed [SAMPLE_W-1:0]  contour_level;
  logic                        pipe_en;
  logic                        take_ok;
  logic                        v3;
  side_t                       side3;
  lane_in_t [LANES-1:0]        lanes3;
  logic [LANES-1:0][Q_W-1:0]   quot;
  logic [DIV_STAGES-1:0]       vd;
  side_t                       sd [DIV_STAGES];
  logic                        cell_valid_last;

  always_ff @(posedge clk) begin
    if (rst) contour_level <= '0;
    else if (level_we) contour_level <= level_wdata;
  end

  assign cell_valid_last = vd[DIV_STAGES-1];
  assign pipe_en  = take_ok || !cell_valid_last;
  assign in_stall = !pipe_en;

  ccs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (pipe_en),
    .in_valid      (in_valid),
    .corner_00     (corner_00),
    .corner_10     (corner_10),
    .corner_11     (corner_11),
    .corner_01     (corner_01),
    .cell_x        (cell_x),
    .cell_y        (cell_y),
    .contour_level (contour_level),
    .cell_valid    (v3),
    .side          (side3),
    .lanes         (lanes3)
  );

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    ccs_div u_div (
      .clk (clk),
      .en  (pipe_en),
      .din (lanes3[l]),
      .q   (quot[l])
    );
  end

  // sideband travels beside the divider stages
  always_ff @(posedge clk) begin
    if (rst) vd <= '0;
    else if (pipe_en) vd <= {vd[DIV_STAGES-2:0], v3};
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sd[0] <= side3;
      for (int k = 1; k < DIV_STAGES; k++) sd[k] <= sd[k-1];
    end
  end

  ccs_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (cell_valid_last),
    .side         (sd[DIV_STAGES-1]),
    .quot         (quot),
    .out_stall    (out_stall),
    .take_ok      (take_ok),
    .out_valid    (out_valid),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .last_segment (last_segment)
  );

  `CCS_ASSERT_NOW(a_halt_needs_full, !pipe_en, cell_valid_last, "pipe halted while last stage empty")
  `CCS_ASSERT_NEXT(a_more_follows, out_valid && !out_stall && !last_segment, out_valid, "cell ended without last beat")
  `CCS_ASSERT_NOW(a_no_take_midcell, out_valid && out_stall && !last_segment, !take_ok, "buffer overwritten mid cell")

endmodule

`default_nettype wire
